// ===== src/krt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_pkg
// Record layout, command codes and status codes of the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int unsigned REC_W = 200;

  typedef struct packed {
    logic [39:0] stamp;
    logic [31:0] group;
    logic [63:0] name;
    logic [63:0] id;
  } krt_rec_t;

  localparam logic [2:0] CMD_APPEND   = 3'd0;
  localparam logic [2:0] CMD_FIND     = 3'd1;
  localparam logic [2:0] CMD_RM_FIRST = 3'd2;
  localparam logic [2:0] CMD_RM_LAST  = 3'd3;
  localparam logic [2:0] CMD_RM_ID    = 3'd4;
  localparam logic [2:0] CMD_SORT_ID  = 3'd5;
  localparam logic [2:0] CMD_SORT_TM  = 3'd6;
  localparam logic [2:0] CMD_LIST     = 3'd7;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

endpackage

// ===== src/krt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_ram
// Single-port record memory, registered read.
// ----------------------------------------------------------------------------
module krt_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       addr,
  input  krt_pkg::krt_rec_t   wdata,
  output krt_pkg::krt_rec_t   rdata
);
  import krt_pkg::*;

  krt_rec_t mem [DEPTH];

  // write-first is not needed: controller never reads what it just wrote
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== src/keyed_record_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_table
// Ordered record table with append, search, compaction, sort and listing.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command per transfer; tdata = {stamp, group, name, id, mode}.
//   out_* : result transfers; out_tlast marks the final result of a command.
//   All records sit in one single-port memory (one access per cycle).
//   Append, remove last, full or empty: result registered via S_DISP, S_OUT.
//   Find: records are read and compared in order up to the match.
//   Remove first / remove by id: later records move down one place each.
//   List: records read out in order. Sort: insertion sort by id or stamp,
//   shifting larger records up one place; the sorted table is then listed.
//   One command is handled at a time; in_tready is low while busy and while
//   a result transfer is still waiting in the output register.
//   A stalled receiver holds the output register and the sequencer waits.
//   Reset empties the table (fill count only); no clearing pass.
// ----------------------------------------------------------------------------
module keyed_record_table #(
  parameter int unsigned DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mode[2:0], student_id[66:3], holder_name[130:67], group_label[162:131],
  // stamp[202:163], zero pad to 208
  input  logic [207:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], out_id[65:2], out_name[129:66], out_group[161:130],
  // out_stamp[201:162], entry_count[208:202], pad to 216
  output logic [215:0] out_tdata,
  output logic         out_tlast
);
  import krt_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [6:0] DEPTH_C = 7'(DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_FRD   = 4'd2;  // find scan: read issued
  localparam logic [3:0] S_FCHK  = 4'd3;
  localparam logic [3:0] S_MRD   = 4'd4;  // compaction: read j+1
  localparam logic [3:0] S_MWR   = 4'd5;  // write to j
  localparam logic [3:0] S_LRD   = 4'd6;  // list read
  localparam logic [3:0] S_LOUT  = 4'd7;
  localparam logic [3:0] S_SKEY  = 4'd8;  // sort: read key rec i
  localparam logic [3:0] S_SKEYW = 4'd9;
  localparam logic [3:0] S_SPRD  = 4'd10; // read j-1
  localparam logic [3:0] S_SCMP  = 4'd11;
  localparam logic [3:0] S_SPUT  = 4'd12; // write key at j
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0]  st_r, st_nxt;
  logic [2:0]  mode_r, mode_nxt;
  krt_rec_t    cmd_r, cmd_nxt;
  krt_rec_t    key_r, key_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [6:0]  i_r, i_nxt;
  logic [6:0]  j_r, j_nxt;
  logic        ov_r, ov_nxt;
  logic        ol_r, ol_nxt;
  logic [1:0]  os_r, os_nxt;
  krt_rec_t    orec_r, orec_nxt;

  logic        we;
  logic [6:0]  addr;
  krt_rec_t    wdata, rdata;

  krt_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk(clk), .we(we), .addr(addr[AW-1:0]), .wdata(wdata), .rdata(rdata)
  );

  logic out_free;
  assign out_free  = !ov_r || out_tready;
  // new command only once the previous result has left the output register
  assign in_tready = (st_r == S_IDLE) && !ov_r;

  always_comb begin
    logic [39:0] kv, pv;
    st_nxt = st_r; mode_nxt = mode_r; cmd_nxt = cmd_r; key_nxt = key_r;
    cnt_nxt = cnt_r; i_nxt = i_r; j_nxt = j_r;
    ov_nxt = ov_r && !out_tready; ol_nxt = ol_r; os_nxt = os_r; orec_nxt = orec_r;
    we = 1'b0; addr = j_r; wdata = key_r;
    kv = '0; pv = '0;
    case (st_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          mode_nxt = in_tdata[2:0];
          cmd_nxt  = in_tdata[202:3];
          st_nxt   = S_DISP;
        end
      end
      S_DISP: begin
        orec_nxt = '0; os_nxt = ST_OK; ol_nxt = 1'b1;
        j_nxt = 7'd0; i_nxt = 7'd1; st_nxt = S_OUT;
        if (mode_r == CMD_APPEND) begin
          if (cnt_r >= DEPTH_C) begin
            os_nxt = ST_FULL;
          end else begin
            we = 1'b1; addr = cnt_r; wdata = cmd_r;
            cnt_nxt = cnt_r + 7'd1;
          end
        end else if (cnt_r == 7'd0) begin
          os_nxt = ST_EMPTY;
        end else begin
          case (mode_r)
            CMD_FIND, CMD_RM_ID: begin addr = 7'd0; st_nxt = S_FCHK; end
            CMD_RM_FIRST: st_nxt = S_MRD;
            CMD_RM_LAST:  cnt_nxt = cnt_r - 7'd1;
            CMD_SORT_ID, CMD_SORT_TM: st_nxt = S_SKEY;
            default: st_nxt = S_LRD;
          endcase
        end
      end
      S_FRD: begin
        addr = j_r; st_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (rdata.id == cmd_r.id) begin
          ol_nxt = 1'b1; os_nxt = ST_OK;
          if (mode_r == CMD_FIND) begin
            orec_nxt = rdata; st_nxt = S_OUT;
          end else begin
            st_nxt = S_MRD;
          end
        end else if (j_r + 7'd1 >= cnt_r) begin
          os_nxt = ST_MISSING; st_nxt = S_OUT;
        end else begin
          j_nxt = j_r + 7'd1; st_nxt = S_FRD;
        end
      end
      S_MRD: begin
        if (j_r + 7'd1 >= cnt_r) begin
          cnt_nxt = cnt_r - 7'd1; orec_nxt = '0; os_nxt = ST_OK; st_nxt = S_OUT;
        end else begin
          addr = j_r + 7'd1; st_nxt = S_MWR;
        end
      end
      S_MWR: begin
        we = 1'b1; addr = j_r; wdata = rdata;
        j_nxt = j_r + 7'd1; st_nxt = S_MRD;
      end
      S_SKEY: begin
        if (i_r >= cnt_r) begin
          j_nxt = 7'd0; st_nxt = S_LRD;
        end else begin
          addr = i_r; j_nxt = i_r; st_nxt = S_SKEYW;
        end
      end
      S_SKEYW: begin
        key_nxt = rdata; st_nxt = S_SPRD;
      end
      S_SPRD: begin
        if (j_r == 7'd0) begin
          st_nxt = S_SPUT;
        end else begin
          addr = j_r - 7'd1; st_nxt = S_SCMP;
        end
      end
      S_SCMP: begin
        kv = key_r.stamp; pv = rdata.stamp;
        if (mode_r == CMD_SORT_ID ? (rdata.id <= key_r.id) : (pv <= kv)) begin
          st_nxt = S_SPUT;
        end else begin
          we = 1'b1; addr = j_r; wdata = rdata;
          j_nxt = j_r - 7'd1; st_nxt = S_SPRD;
        end
      end
      S_SPUT: begin
        we = 1'b1; addr = j_r; wdata = key_r;
        i_nxt = i_r + 7'd1; st_nxt = S_SKEY;
      end
      S_LRD: begin
        addr = j_r; st_nxt = S_LOUT;
      end
      S_LOUT: begin
        if (out_free) begin
          ov_nxt = 1'b1; orec_nxt = rdata; os_nxt = ST_OK;
          ol_nxt = (j_r + 7'd1 == cnt_r);
          j_nxt = j_r + 7'd1;
          st_nxt = (j_r + 7'd1 == cnt_r) ? S_IDLE : S_LRD;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
    end
    mode_r <= mode_nxt; cmd_r <= cmd_nxt; key_r <= key_nxt;
    i_r <= i_nxt; j_r <= j_nxt; ol_r <= ol_nxt; os_r <= os_nxt; orec_r <= orec_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = ol_r;
  assign out_tdata  = {7'd0, cnt_r, orec_r, os_r};

endmodule
